// File: rtl/core/apt_pkg.sv
// shared types and constants for the attribute pair tokenizer
package apt_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [2:0] kind_t;
    typedef logic [2:0] phase_t;

    // result kinds
    localparam kind_t KIND_SKIP   = 3'd0;
    localparam kind_t KIND_NAME   = 3'd1;
    localparam kind_t KIND_VALUE  = 3'd2;
    localparam kind_t KIND_PAIR   = 3'd3;
    localparam kind_t KIND_SYNTAX = 3'd4;
    localparam kind_t KIND_UNBAL  = 3'd5;

    // character codes
    localparam byte_t CHAR_NUL    = 8'd0;
    localparam byte_t CHAR_TAB    = 8'd9;
    localparam byte_t CHAR_SPACE  = 8'd32;
    localparam byte_t CHAR_DQUOTE = 8'd34;
    localparam byte_t CHAR_SQUOTE = 8'd39;
    localparam byte_t CHAR_EQUALS = 8'd61;

    // space or tab
    function automatic logic is_ws(input byte_t c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB);
    endfunction

    // ascii letter or digit
    function automatic logic is_alnum(input byte_t c);
        return ((c >= 8'd48) && (c <= 8'd57)) ||
               ((c >= 8'd65) && (c <= 8'd90)) ||
               ((c >= 8'd97) && (c <= 8'd122));
    endfunction

endpackage

// File: rtl/core/attribute_pair_tokenizer_core.sv
// attribute pair tokenizer: byte classifier and pair state machine with result register
//
// Takes one byte of an attribute string per transfer and returns one result per byte:
// kind (skipped, name byte, value byte, pair complete, syntax error, unbalanced quote),
// the echoed byte for name and value bytes, and string_done on the zero terminator,
// which also returns the parser to its start state. One byte is accepted every cycle
// while the result register is free or draining; each result appears in the cycle after
// its byte is taken, from a single result register loaded while the previous result is
// taken, so throughput is one byte per cycle while out_ready stays high. The phase
// register and quote flag form the only loop and update when the byte is taken.
module attribute_pair_tokenizer_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] kind,
    output logic [7:0] byte_out,
    output logic       string_done
);

    // parse phases
    localparam apt_pkg::phase_t PH_BETWEEN = 3'd0;
    localparam apt_pkg::phase_t PH_NAME    = 3'd1;
    localparam apt_pkg::phase_t PH_SEP     = 3'd2;
    localparam apt_pkg::phase_t PH_EQ      = 3'd3;
    localparam apt_pkg::phase_t PH_UNQ     = 3'd4;
    localparam apt_pkg::phase_t PH_QUOTED  = 3'd5;
    localparam apt_pkg::phase_t PH_ERROR   = 3'd6;

    apt_pkg::phase_t phase_reg;
    apt_pkg::phase_t phase_next;
    logic            dquote_reg;
    logic            dquote_next;
    logic            out_valid_reg;
    apt_pkg::kind_t  kind_reg;
    apt_pkg::kind_t  kind_next;
    apt_pkg::byte_t  byte_reg;
    apt_pkg::byte_t  byte_next;
    logic            done_reg;
    logic            in_xfer;
    logic            c_ws;
    logic            c_alnum;
    logic            c_nul;
    logic            c_eq;
    apt_pkg::byte_t  close_quote;

    // accept whenever the result register is free or being drained
    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    // byte classes
    assign c_ws        = apt_pkg::is_ws(char_code);
    assign c_alnum     = apt_pkg::is_alnum(char_code);
    assign c_nul       = (char_code == apt_pkg::CHAR_NUL);
    assign c_eq        = (char_code == apt_pkg::CHAR_EQUALS);
    assign close_quote = dquote_reg ? apt_pkg::CHAR_DQUOTE : apt_pkg::CHAR_SQUOTE;

    // phase transition and result for the incoming byte
    always_comb
    begin
        apt_pkg::phase_t nxt;
        nxt         = phase_reg;
        kind_next   = apt_pkg::KIND_SKIP;
        byte_next   = apt_pkg::CHAR_NUL;
        dquote_next = dquote_reg;
        unique case (phase_reg)
            PH_BETWEEN:
            begin
                priority if (c_nul || c_ws)
                begin
                    kind_next = apt_pkg::KIND_SKIP;
                end
                else if (c_alnum)
                begin
                    kind_next = apt_pkg::KIND_NAME;
                    byte_next = char_code;
                    nxt       = PH_NAME;
                end
                else if (c_eq)
                begin
                    nxt = PH_EQ;
                end
                else
                begin
                    nxt = PH_SEP;
                end
            end
            PH_NAME:
            begin
                priority if (c_nul)
                begin
                    kind_next = apt_pkg::KIND_SYNTAX;
                end
                else if (c_alnum)
                begin
                    kind_next = apt_pkg::KIND_NAME;
                    byte_next = char_code;
                end
                else if (c_eq)
                begin
                    nxt = PH_EQ;
                end
                else
                begin
                    nxt = PH_SEP;
                end
            end
            PH_SEP:
            begin
                priority if (c_ws)
                begin
                    kind_next = apt_pkg::KIND_SKIP;
                end
                else if (c_eq)
                begin
                    nxt = PH_EQ;
                end
                else
                begin
                    kind_next = apt_pkg::KIND_SYNTAX;
                    nxt       = PH_ERROR;
                end
            end
            PH_EQ:
            begin
                priority if (c_ws)
                begin
                    kind_next = apt_pkg::KIND_SKIP;
                end
                else if ((char_code == apt_pkg::CHAR_DQUOTE) ||
                         (char_code == apt_pkg::CHAR_SQUOTE))
                begin
                    dquote_next = (char_code == apt_pkg::CHAR_DQUOTE);
                    nxt         = PH_QUOTED;
                end
                else if (c_alnum)
                begin
                    kind_next = apt_pkg::KIND_VALUE;
                    byte_next = char_code;
                    nxt       = PH_UNQ;
                end
                else
                begin
                    kind_next = apt_pkg::KIND_PAIR;
                    nxt       = PH_BETWEEN;
                end
            end
            PH_UNQ:
            begin
                if (c_alnum)
                begin
                    kind_next = apt_pkg::KIND_VALUE;
                    byte_next = char_code;
                end
                else
                begin
                    kind_next = apt_pkg::KIND_PAIR;
                    nxt       = PH_BETWEEN;
                end
            end
            PH_QUOTED:
            begin
                priority if (c_nul)
                begin
                    kind_next = apt_pkg::KIND_UNBAL;
                end
                else if (char_code == close_quote)
                begin
                    kind_next = apt_pkg::KIND_PAIR;
                    nxt       = PH_BETWEEN;
                end
                else
                begin
                    kind_next = apt_pkg::KIND_VALUE;
                    byte_next = char_code;
                end
            end
            default:
            begin
                // error phase and the unused code ignore bytes
                kind_next = apt_pkg::KIND_SKIP;
            end
        endcase
        // terminator returns to start
        if (c_nul)
        begin
            phase_next  = PH_BETWEEN;
            dquote_next = 1'b0;
        end
        else
        begin
            phase_next = nxt;
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_BETWEEN;
            dquote_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            phase_reg  <= phase_next;
            dquote_reg <= dquote_next;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            kind_reg <= kind_next;
            byte_reg <= byte_next;
            done_reg <= c_nul;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign byte_out    = byte_reg;
    assign string_done = done_reg;

endmodule
